// ----- rtl/app_param_tlv_parser_assert.svh -----
// Assertion macros shared by the parser RTL.
`ifndef APP_PARAM_TLV_PARSER_ASSERT_SVH
`define APP_PARAM_TLV_PARSER_ASSERT_SVH
`ifndef SYNTH
// checked only out of reset
`define APT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define APT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define APT_ASSERT(lbl, clk, rstn, prop, msg)
`define APT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/apt_pkg.sv -----
`default_nettype none
package apt_pkg;

	typedef enum logic [1:0] {
		PH_TAG = 2'd0,
		PH_LEN = 2'd1,
		PH_VAL = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADLEN = 2'd1,
		ST_BADTAG = 2'd2,
		ST_TRUNC  = 2'd3
	} status_t;

	localparam logic [7:0] TAG_ORDER  = 8'h01;
	localparam logic [7:0] TAG_SEARCH = 8'h02;
	localparam logic [7:0] TAG_ATTRIB = 8'h03;
	localparam logic [7:0] TAG_COUNT  = 8'h04;
	localparam logic [7:0] TAG_OFFSET = 8'h05;
	localparam logic [7:0] TAG_FILTER = 8'h06;
	localparam logic [7:0] TAG_FORMAT = 8'h07;

	localparam logic [7:0] LEN_BYTE   = 8'd1;
	localparam logic [7:0] LEN_WORD   = 8'd2;
	localparam logic [7:0] LEN_FILTER = 8'd8;

	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_CNT_W = 3;
	localparam int TDATA_W   = 136;

	typedef struct packed {
		logic        kind;
		status_t     status;
		logic        given;
		logic [15:0] offset;
		logic [15:0] count;
		logic [7:0]  format;
		logic [63:0] filter;
		logic [7:0]  attrib;
		logic [7:0]  order;
		logic [7:0]  sbyte;
	} result_t;

	typedef struct packed {
		logic first;
		logic second;
	} res_push_t;

	function automatic logic len_ok(input logic [7:0] tag, input logic [7:0] len);
		logic ok;
		case (tag)
			TAG_ORDER, TAG_ATTRIB, TAG_FORMAT: ok = (len == LEN_BYTE);
			TAG_COUNT, TAG_OFFSET:             ok = (len == LEN_WORD);
			TAG_FILTER:                        ok = (len == LEN_FILTER);
			TAG_SEARCH:                        ok = (len != 8'd0);
			default:                           ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/apt_parse.sv -----
`default_nettype none
`include "app_param_tlv_parser_assert.svh"
module apt_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire logic [7:0]        in_byte,
	input  wire logic              in_last,
	output apt_pkg::result_t       res0,
	output apt_pkg::result_t       res1,
	output apt_pkg::res_push_t     push
);

	apt_pkg::phase_t  phase_q, phase_n;
	apt_pkg::status_t err_q, err_n;
	logic [7:0]  tag_q, tag_n;
	logic [7:0]  left_q, left_n;
	logic [63:0] shift_q, shift_n;
	logic [7:0]  order_q, order_n;
	logic [7:0]  attrib_q, attrib_n;
	logic [63:0] filter_q, filter_n;
	logic [7:0]  format_q, format_n;
	logic [15:0] count_q, count_n;
	logic [15:0] offset_q, offset_n;
	logic        seen_q, seen_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= apt_pkg::PH_TAG;
			err_q    <= apt_pkg::ST_OK;
			tag_q    <= '0;
			left_q   <= '0;
			shift_q  <= '0;
			order_q  <= '0;
			attrib_q <= '0;
			filter_q <= '0;
			format_q <= '0;
			count_q  <= '0;
			offset_q <= '0;
			seen_q   <= 1'b0;
		end else if (acc) begin
			phase_q  <= phase_n;
			err_q    <= err_n;
			tag_q    <= tag_n;
			left_q   <= left_n;
			shift_q  <= shift_n;
			order_q  <= order_n;
			attrib_q <= attrib_n;
			filter_q <= filter_n;
			format_q <= format_n;
			count_q  <= count_n;
			offset_q <= offset_n;
			seen_q   <= seen_n;
		end
	end

	always_comb begin
		apt_pkg::result_t srch;
		apt_pkg::result_t fin;
		logic             srch_v;
		phase_n  = phase_q;
		err_n    = err_q;
		tag_n    = tag_q;
		left_n   = left_q;
		shift_n  = shift_q;
		order_n  = order_q;
		attrib_n = attrib_q;
		filter_n = filter_q;
		format_n = format_q;
		count_n  = count_q;
		offset_n = offset_q;
		seen_n   = seen_q;
		srch_v   = 1'b0;
		srch     = '0;
		fin      = '0;

		if (err_q == apt_pkg::ST_OK) begin
			case (phase_q)
				apt_pkg::PH_TAG: begin
					tag_n = in_byte;
					if (in_byte >= apt_pkg::TAG_ORDER && in_byte <= apt_pkg::TAG_FORMAT)
						phase_n = apt_pkg::PH_LEN;
					else
						err_n = apt_pkg::ST_BADTAG;
				end
				apt_pkg::PH_LEN: begin
					if (!apt_pkg::len_ok(tag_q, in_byte)) begin
						err_n = apt_pkg::ST_BADLEN;
					end else begin
						left_n  = in_byte;
						shift_n = '0;
						phase_n = apt_pkg::PH_VAL;
						if (tag_q == apt_pkg::TAG_SEARCH)
							seen_n = 1'b1;
					end
				end
				apt_pkg::PH_VAL: begin
					shift_n = {shift_q[55:0], in_byte};
					srch_v  = (tag_q == apt_pkg::TAG_SEARCH);
					left_n  = left_q - 8'd1;
					if (left_n == 8'd0) begin
						phase_n = apt_pkg::PH_TAG;
						case (tag_q)
							apt_pkg::TAG_ORDER:  order_n  = shift_n[7:0];
							apt_pkg::TAG_ATTRIB: attrib_n = shift_n[7:0];
							apt_pkg::TAG_FORMAT: format_n = shift_n[7:0];
							apt_pkg::TAG_COUNT:  count_n  = shift_n[15:0];
							apt_pkg::TAG_OFFSET: offset_n = shift_n[15:0];
							apt_pkg::TAG_FILTER: filter_n = shift_n;
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end

		srch.kind  = 1'b0;
		srch.sbyte = in_byte;

		fin.kind   = 1'b1;
		fin.order  = order_n;
		fin.attrib = attrib_n;
		fin.filter = filter_n;
		fin.format = format_n;
		fin.count  = count_n;
		fin.offset = offset_n;
		fin.given  = seen_n;
		if (err_n != apt_pkg::ST_OK)
			fin.status = err_n;
		else if (phase_n != apt_pkg::PH_TAG)
			fin.status = apt_pkg::ST_TRUNC;
		else
			fin.status = apt_pkg::ST_OK;

		// block end drops all collected state back to reset values
		if (in_last) begin
			phase_n  = apt_pkg::PH_TAG;
			err_n    = apt_pkg::ST_OK;
			tag_n    = '0;
			left_n   = '0;
			shift_n  = '0;
			order_n  = '0;
			attrib_n = '0;
			filter_n = '0;
			format_n = '0;
			count_n  = '0;
			offset_n = '0;
			seen_n   = 1'b0;
		end

		// compact: search byte goes first when both are produced
		res0        = srch_v ? srch : fin;
		res1        = fin;
		push.first  = acc && (srch_v || in_last);
		push.second = acc && srch_v && in_last;
	end

	`APT_ASSERT(a_end_clears, clk, arst_n,
		(acc && in_last) |=> (phase_q == apt_pkg::PH_TAG && err_q == apt_pkg::ST_OK && !seen_q),
		"parser state not cleared after block end")
	`APT_ASSERT(a_err_sticky, clk, arst_n,
		(acc && !in_last && err_q != apt_pkg::ST_OK) |=> $stable(err_q),
		"error code changed inside a block")
	`APT_ASSERT(a_seen_from_len, clk, arst_n,
		$rose(seen_q) |-> $past(phase_q == apt_pkg::PH_LEN && tag_q == apt_pkg::TAG_SEARCH),
		"search flag set outside a search length byte")
	`APT_ASSERT(a_val_left, clk, arst_n,
		(phase_q == apt_pkg::PH_VAL) |-> (left_q != 8'd0),
		"value phase with no bytes left")

endmodule
`default_nettype wire

// ----- rtl/apt_res_fifo.sv -----
`default_nettype none
`include "app_param_tlv_parser_assert.svh"
module apt_res_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire apt_pkg::result_t   res0,
	input  wire apt_pkg::result_t   res1,
	input  wire apt_pkg::res_push_t push,
	output logic                    room,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output apt_pkg::result_t        out_res
);

	apt_pkg::result_t ent_q [apt_pkg::RES_DEPTH];
	logic [apt_pkg::RES_PTR_W-1:0] wr_q, rd_q, wr_nx;
	logic [apt_pkg::RES_CNT_W-1:0] cnt_q, n_push;
	logic                          pop;

	assign n_push    = apt_pkg::RES_CNT_W'(push.first) + apt_pkg::RES_CNT_W'(push.second);
	assign wr_nx     = wr_q + apt_pkg::RES_PTR_W'(1);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = ent_q[rd_q];
	// two slots must be free, since one input byte can produce two results
	assign room      = (cnt_q <= apt_pkg::RES_CNT_W'(apt_pkg::RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.first)
			ent_q[wr_q] <= res0;
		if (push.second)
			ent_q[wr_nx] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[apt_pkg::RES_PTR_W-1:0];
			rd_q  <= rd_q + apt_pkg::RES_PTR_W'(pop);
			cnt_q <= cnt_q + n_push - apt_pkg::RES_CNT_W'(pop);
		end
	end

	`APT_ASSERT(a_cnt_bound, clk, arst_n,
		cnt_q <= apt_pkg::RES_CNT_W'(apt_pkg::RES_DEPTH),
		"result queue count out of range")
	`APT_ASSERT(a_push_room, clk, arst_n,
		push.first |-> room,
		"result pushed without room")
	`APT_ASSERT_ALWAYS(a_second_pair, clk,
		push.second |-> push.first,
		"second result pushed alone")
	`APT_ASSERT(a_ptr_track, clk, arst_n,
		(wr_q - rd_q) == cnt_q[apt_pkg::RES_PTR_W-1:0],
		"queue pointers disagree with count")

endmodule
`default_nettype wire

// ----- rtl/app_param_tlv_parser.sv -----
// Application-parameter TLV parser.
// Input stream s_axis: one byte of the parameter block per transaction in
// tdata[7:0]; tlast marks the block's final byte. Output stream m_axis:
// tuser is the result kind (0 search value byte, 1 parameter set), tdata
// carries the fields. A search value byte is passed out for every value
// byte of a search item; the parameter set with status comes out for the
// block's last byte, after that byte's search result if it has one.
// Each result enters the result queue when its input byte is accepted.
// Throughput: one input byte per cycle; tready stays high while the
// four-entry result queue has two free slots, so a slow receiver only
// stalls the input once two results are queued beyond the one being shown.
// Output payload holds while m_axis_tvalid is high and tready is low.
// Reset clears the parse state, collected fields and the result queue;
// the next byte after reset or after a block end is taken as a tag.
`default_nettype none
module app_param_tlv_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // [7:0] in_byte
	input  wire logic         s_axis_tlast,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// [7:0] search_byte, [15:8] sort_order, [23:16] search_attribute,
	// [87:24] property_filter, [95:88] vcard_format, [111:96] max_list_count,
	// [127:112] list_start_offset, [128] search_given, [130:129] parse_status,
	// [135:131] zero
	output logic [apt_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic              m_axis_tuser   // [0] result_kind
);

	apt_pkg::result_t   res0, res1, out_res;
	apt_pkg::res_push_t push;
	logic               room;
	logic               acc;

	assign s_axis_tready = room;
	assign acc           = s_axis_tvalid && room;

	apt_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.in_byte (s_axis_tdata),
		.in_last (s_axis_tlast),
		.res0    (res0),
		.res1    (res1),
		.push    (push)
	);

	apt_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.res0      (res0),
		.res1      (res1),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tuser = out_res.kind;
	assign m_axis_tdata = {5'd0, out_res.status, out_res.given, out_res.offset,
		out_res.count, out_res.format, out_res.filter, out_res.attrib,
		out_res.order, out_res.sbyte};

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import apt_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 400;

	// expected outputs of the parser, kept in arrival order
	class tlv_scoreboard;
		phase_t      parse_ph;
		logic [7:0]  cur_tag;
		logic [7:0]  remaining;
		logic [63:0] shift_reg;
		logic [7:0]  order_val;
		logic [7:0]  attrib_val;
		logic [63:0] filter_val;
		logic [7:0]  format_val;
		logic [15:0] count_val;
		logic [15:0] offset_val;
		logic        search_flag;
		status_t     err;
		result_t     pending_results[$];
		int          mismatches;

		function new();
			clear_block();
			mismatches = 0;
		endfunction

		function void clear_block();
			parse_ph = PH_TAG;
			cur_tag = '0;
			remaining = '0;
			shift_reg = '0;
			order_val = '0;
			attrib_val = '0;
			filter_val = '0;
			format_val = '0;
			count_val = '0;
			offset_val = '0;
			search_flag = 1'b0;
			err = ST_OK;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// advance the parse by one accepted input transaction
		function void take_byte(logic [7:0] b, logic last);
			result_t r;
			status_t st;
			logic    fits;
			if (err == ST_OK) begin
				case (parse_ph)
					PH_TAG: begin
						cur_tag = b;
						if (b >= TAG_ORDER && b <= TAG_FORMAT)
							parse_ph = PH_LEN;
						else
							err = ST_BADTAG;
					end
					PH_LEN: begin
						// tag is known valid here
						if (cur_tag == TAG_SEARCH)
							fits = (b != 8'd0);
						else if (cur_tag == TAG_FILTER)
							fits = (b == LEN_FILTER);
						else if (cur_tag == TAG_COUNT || cur_tag == TAG_OFFSET)
							fits = (b == LEN_WORD);
						else
							fits = (b == LEN_BYTE);
						if (!fits) begin
							err = ST_BADLEN;
						end else begin
							remaining = b;
							shift_reg = '0;
							parse_ph = PH_VAL;
							if (cur_tag == TAG_SEARCH)
								search_flag = 1'b1;
						end
					end
					default: begin
						shift_reg = {shift_reg[55:0], b};
						if (cur_tag == TAG_SEARCH) begin
							r = '0;
							r.sbyte = b;
							pending_results.push_back(r);
						end
						remaining = remaining - 8'd1;
						if (remaining == 8'd0) begin
							case (cur_tag)
								TAG_ORDER:  order_val = shift_reg[7:0];
								TAG_ATTRIB: attrib_val = shift_reg[7:0];
								TAG_FORMAT: format_val = shift_reg[7:0];
								TAG_COUNT:  count_val = shift_reg[15:0];
								TAG_OFFSET: offset_val = shift_reg[15:0];
								TAG_FILTER: filter_val = shift_reg;
								default: ;
							endcase
							parse_ph = PH_TAG;
						end
					end
				endcase
			end
			if (last) begin
				st = err;
				if (st == ST_OK && parse_ph != PH_TAG)
					st = ST_TRUNC;
				r = '0;
				r.kind = 1'b1;
				r.order = order_val;
				r.attrib = attrib_val;
				r.filter = filter_val;
				r.format = format_val;
				r.count = count_val;
				r.offset = offset_val;
				r.given = search_flag;
				r.status = st;
				pending_results.push_back(r);
				clear_block();
			end
		endfunction

		task report(string what);
			mismatches++;
			$display("mismatch %0d at %0t: %s", mismatches, $time, what);
		endtask

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("%s got %0h expected %0h", name, got, want));
		endtask

		task check(logic [TDATA_W-1:0] data, logic user);
			result_t got;
			result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result kind %0d arrived with none expected", user));
				return;
			end
			want = pending_results.pop_front();
			// tdata matches the struct layout below the kind bit
			got = result_t'({user, data[$bits(result_t)-2:0]});
			compare_field("result_kind", got.kind, want.kind);
			compare_field("search_byte", got.sbyte, want.sbyte);
			compare_field("sort_order", got.order, want.order);
			compare_field("search_attribute", got.attrib, want.attrib);
			compare_field("property_filter", got.filter, want.filter);
			compare_field("vcard_format", got.format, want.format);
			compare_field("max_list_count", got.count, want.count);
			compare_field("list_start_offset", got.offset, want.offset);
			compare_field("search_given", got.given, want.given);
			compare_field("parse_status", got.status, want.status);
			compare_field("tdata pad", data[TDATA_W-1:$bits(result_t)-1], '0);
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'h00;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;

	tlv_scoreboard sb;
	int tx_count = 0;
	int idle_cycles = 0;
	int hold_req = 0;
	int rx_stall = 0;
	bit tx_jitter = 1'b0;
	bit rx_jitter = 1'b0;

	app_param_tlv_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly zero, mostly short otherwise, now and then long
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 60);
	endfunction

	// receiver: random stalls, plus a long hold when asked
	always @(posedge clk) begin
		if (hold_req != 0) begin
			rx_stall = hold_req;
			hold_req = 0;
		end else if (rx_stall == 0 && rx_jitter) begin
			rx_stall = pick_gap();
		end
		if (rx_stall != 0) begin
			m_axis_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// sample mid-cycle: values are settled for the coming rising edge
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata, m_axis_tuser);
	end

	always @(negedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// called and returns at a rising edge
	task send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_jitter ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(negedge clk); while (!s_axis_tready);
		sb.take_byte(b, last);
		tx_count++;
		@(posedge clk);
	endtask

	task send_block(input byte_q_t blk);
		foreach (blk[i])
			send_byte(blk[i], i == blk.size() - 1);
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// well-formed items with random content; some noise and broken blocks
	task random_block();
		byte_q_t blk;
		logic [7:0] t;
		int len;
		int r;
		int cut;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6)) blk.push_back(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 5)) begin
				t = 8'($urandom_range(TAG_ORDER, TAG_FORMAT));
				case (t)
					TAG_SEARCH: len = ($urandom_range(0, 7) == 0) ?
						$urandom_range(5, 16) : $urandom_range(1, 4);
					TAG_FILTER: len = LEN_FILTER;
					TAG_COUNT, TAG_OFFSET: len = LEN_WORD;
					default: len = LEN_BYTE;
				endcase
				blk.push_back(t);
				blk.push_back(8'(len));
				repeat (len) blk.push_back(8'($urandom));
			end
			r = $urandom_range(0, 19);
			if (r < 2) begin
				blk[1] = 8'($urandom);
			end else if (r < 4) begin
				blk[$urandom_range(0, blk.size() - 1)] = 8'($urandom);
			end else if (r < 7) begin
				cut = $urandom_range(1, blk.size() - 1);
				while (blk.size() > cut) void'(blk.pop_back());
			end
		end
		send_block(blk);
	endtask

	initial begin
		byte_q_t burst;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_block('{8'h00});
		send_block('{8'hFF});
		// wrong length, then the rest is ignored
		send_block('{TAG_ORDER, LEN_WORD, 8'h55});
		send_block('{TAG_FILTER, LEN_FILTER, 8'hFF, 8'h00, 8'h80, 8'h01,
			8'hFE, 8'h7F, 8'hAA, 8'h55});
		// search byte and parameter set on the same transaction
		send_block('{TAG_SEARCH, LEN_BYTE, 8'hFF});
		send_block('{TAG_SEARCH, 8'h00});
		send_block('{TAG_COUNT});
		send_block('{TAG_OFFSET, LEN_WORD, 8'h12});
		drain();

		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		while (tx_count < 24 + RANDOM_ITEMS / 2) random_block();
		drain();

		// long receiver hold while a long search item keeps coming
		tx_jitter = 1'b0;
		hold_req = 250;
		@(posedge clk);
		burst.push_back(TAG_SEARCH);
		burst.push_back(8'd20);
		repeat (20) burst.push_back(8'($urandom));
		send_block(burst);
		drain();

		while (tx_count < 24 + RANDOM_ITEMS) begin
			tx_jitter = ($urandom_range(0, 3) != 0);
			rx_jitter = ($urandom_range(0, 3) != 0);
			random_block();
		end
		drain();

		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ----- app_param_tlv_parser.f -----
+incdir+rtl
rtl/apt_pkg.sv
rtl/apt_parse.sv
rtl/apt_res_fifo.sv
rtl/app_param_tlv_parser.sv
verif/testbench.sv
